### rtl/crmf_pkg.sv
`default_nettype none

package crmf_pkg;

  // Data width of samples and limits
  localparam int DATA_W = 16;

  // Default window depth
  localparam int DEF_WINDOW = 5;

  // Register reset values
  localparam logic [DATA_W-1:0] LOW_LIMIT_RST = 16'd20;
  localparam logic [DATA_W-1:0] HIGH_LIMIT_RST = 16'd1200;
  localparam logic [DATA_W-1:0] FALLBACK_RST = 16'd1200;

  // Register map (word index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_LOW_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_LIMIT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FALLBACK = 2'd2;

  // APB widths
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Configuration values seen by the datapath
  typedef struct packed {
    logic [DATA_W-1:0] low_limit;
    logic [DATA_W-1:0] high_limit;
    logic [DATA_W-1:0] fallback_value;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture the raw word
    logic cond_write;  // condition sample, write window, restart ranking
    logic rank_step;   // rank the current candidate
    logic out_load;    // move the median into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;         // current candidate is the median
  } sts_t;

endpackage

`default_nettype wire

### rtl/clamped_running_median_filter_core.sv
// Flow: the raw word is captured on accept, then conditioned and stored in the
// window; window entries are then ranked one at a time by the single rank unit
// until the median is found, and the median is loaded into the output register
// once the output is not stalled. A new word is accepted only after that load.
// Reset (rst, synchronous, active high): registers to defaults, window empty,
// last output zero; the window memory itself is not cleared.
`default_nettype none

module clamped_running_median_filter_core #(
  parameter int WINDOW = crmf_pkg::DEF_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crmf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [crmf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [crmf_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [crmf_pkg::DATA_W-1:0]   raw_distance,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [crmf_pkg::DATA_W-1:0]   filtered_distance
);
  import crmf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  crmf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  crmf_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg),
    .raw_distance      (raw_distance),
    .filtered_distance (filtered_distance)
  );

endmodule

`default_nettype wire

### rtl/crmf_regs.sv
`default_nettype none

module crmf_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [crmf_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [crmf_pkg::PDATA_W-1:0]  pwdata,
  output logic      [crmf_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output crmf_pkg::cfg_t                     cfg
);
  import crmf_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; unused index is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_limit      <= LOW_LIMIT_RST;
      cfg.high_limit     <= HIGH_LIMIT_RST;
      cfg.fallback_value <= FALLBACK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LOW_LIMIT:  cfg.low_limit      <= pwdata[DATA_W-1:0];
        REG_HIGH_LIMIT: cfg.high_limit     <= pwdata[DATA_W-1:0];
        REG_FALLBACK:   cfg.fallback_value <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_LOW_LIMIT:  prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg.low_limit};
      REG_HIGH_LIMIT: prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg.high_limit};
      REG_FALLBACK:   prdata = {{(PDATA_W-DATA_W){1'b0}}, cfg.fallback_value};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/crmf_ctrl.sv
`default_nettype none

module crmf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output crmf_pkg::cmd_t     cmd,
  input  crmf_pkg::sts_t     sts
);
  import crmf_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COND = 2'd1;
  localparam logic [1:0] ST_RANK = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_COND;
        end
      end
      ST_COND: begin
        cmd.cond_write = 1'b1;
        state_next     = ST_RANK;
      end
      ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (sts.hit) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  // A pending word is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("output word overwritten while stalled");

  // An accepted word goes straight to conditioning
  a_accept_cond: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> cmd.cond_write)
    else $error("accepted word not conditioned next cycle");

  // A new output word only comes from the finish state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FIN)
    else $error("output valid raised outside finish");
`endif

endmodule

`default_nettype wire

### rtl/crmf_dp.sv
`default_nettype none

module crmf_dp #(
  parameter int WINDOW = crmf_pkg::DEF_WINDOW
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  crmf_pkg::cmd_t                     cmd,
  output crmf_pkg::sts_t                     sts,
  input  crmf_pkg::cfg_t                     cfg,
  input  wire logic [crmf_pkg::DATA_W-1:0]   raw_distance,
  output logic      [crmf_pkg::DATA_W-1:0]   filtered_distance
);
  import crmf_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  logic [DATA_W-1:0] win [WINDOW];
  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] last_output;
  logic [DATA_W-1:0] med;
  logic [DATA_W-1:0] raised;
  logic [DATA_W-1:0] cond_val;
  logic [DATA_W-1:0] cand;
  logic [IDX_W-1:0]  wp;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  rank;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw <= raw_distance;
    end
  end

  // Conditioning: raise to low limit, then replace if above high limit
  always_comb begin
    raised = (raw < cfg.low_limit) ? cfg.low_limit : raw;
    if (raised > cfg.high_limit) begin
      cond_val = (last_output != '0) ? last_output : cfg.fallback_value;
    end else begin
      cond_val = raised;
    end
  end

  // Window store
  always_ff @(posedge clk) begin
    if (cmd.cond_write) begin
      win[wp] <= cond_val;
    end
  end

  // Ring pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      fill <= '0;
    end else if (cmd.cond_write) begin
      wp <= (wp == IDX_W'(WINDOW - 1)) ? '0 : wp + IDX_W'(1);
      if (fill != CNT_W'(WINDOW)) begin
        fill <= fill + CNT_W'(1);
      end
    end
  end

  // Candidate index, one entry ranked per cycle
  always_ff @(posedge clk) begin
    if (cmd.cond_write) begin
      idx <= '0;
    end else if (cmd.rank_step) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Stable rank of the candidate among filled entries
  assign cand = win[idx];
  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if ((CNT_W'(j) < fill) &&
          ((win[j] < cand) || ((win[j] == cand) && (IDX_W'(j) < idx)))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  assign sts.hit = (rank == (fill >> 1));

  always_ff @(posedge clk) begin
    if (cmd.rank_step && sts.hit) begin
      med <= cand;
    end
  end

  // Output register and last result
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_distance <= med;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_output <= '0;
    end else if (cmd.out_load) begin
      last_output <= med;
    end
  end

`ifndef SYNTH
  // The median is always found by the last filled entry
  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    (cmd.rank_step && !sts.hit) |-> ((CNT_W'(idx) + CNT_W'(1)) < fill))
    else $error("ranking ran past the filled entries");

  // Ranking only runs over a non-empty window
  a_rank_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.rank_step |-> (fill != '0))
    else $error("ranking with an empty window");

  // Ring pointer stays inside the window
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    cmd.cond_write |=> (CNT_W'(wp) < CNT_W'(WINDOW)))
    else $error("write pointer out of range");
`endif

endmodule

`default_nettype wire

### bench/clamped_running_median_filter_checker.sv
module clamped_running_median_filter_checker
  import crmf_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DATA_W-1:0]  raw_distance,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [DATA_W-1:0]  filtered_distance,
  output int                 fail_count,
  output int                 open_count
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow of the filter: limits, sample ring, fill level, last median
  cfg_t              limits;
  logic [DATA_W-1:0] ring [WINDOW];
  int                slot;
  int                filled;
  logic [DATA_W-1:0] prev_filtered;
  logic [DATA_W-1:0] median_q [$];
  int unsigned       words_out;

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("%0t ns  %s", $time, what);
  endtask

  // Clamp low first, then swap out readings above the high limit
  function automatic logic [DATA_W-1:0] clean_sample(input logic [DATA_W-1:0] raw);
    logic [DATA_W-1:0] v;
    v = raw;
    if (v < limits.low_limit) v = limits.low_limit;
    if (v > limits.high_limit) v = (prev_filtered != '0) ? prev_filtered : limits.fallback_value;
    return v;
  endfunction

  // Insertion sort of the filled slots; pick index filled/2 (upper median)
  function automatic logic [DATA_W-1:0] middle_of_window();
    logic [DATA_W-1:0] sorted [WINDOW];
    logic [DATA_W-1:0] key;
    int j;
    for (int i = 0; i < filled; i++) sorted[i] = ring[i];
    for (int i = 1; i < filled; i++) begin
      key = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    return sorted[filled/2];
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      limits.low_limit      = LOW_LIMIT_RST;
      limits.high_limit     = HIGH_LIMIT_RST;
      limits.fallback_value = FALLBACK_RST;
      slot          = 0;
      filled        = 0;
      prev_filtered = '0;
      median_q.delete();
      words_out     = 0;
      fail_count    = 0;
    end else begin
      // register writes; index 3 is unmapped and dropped
      if (psel === 1'b1 && penable === 1'b1 && pwrite === 1'b1 && pready === 1'b1) begin
        case (paddr[2 +: REG_IDX_W])
          REG_LOW_LIMIT:  limits.low_limit      = pwdata[DATA_W-1:0];
          REG_HIGH_LIMIT: limits.high_limit     = pwdata[DATA_W-1:0];
          REG_FALLBACK:   limits.fallback_value = pwdata[DATA_W-1:0];
          default: ;
        endcase
      end

      // output word against oldest prediction
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        words_out++;
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("word %0d: unexpected filtered_distance %0d",
                                    words_out, filtered_distance));
        end else begin
          want = median_q.pop_front();
          if (filtered_distance !== want)
            report_mismatch($sformatf("word %0d: filtered_distance %0d, want %0d",
                                      words_out, filtered_distance, want));
        end
      end

      // input word: condition, store in ring, rank
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        ring[slot] = clean_sample(raw_distance);
        slot = (slot + 1) % WINDOW;
        if (filled < WINDOW) filled++;
        prev_filtered = middle_of_window();
        median_q.push_back(prev_filtered);
      end
    end
    open_count = median_q.size();
  end

endmodule

### bench/clamped_running_median_filter_core_test.sv
module clamped_running_median_filter_core_test;

  import crmf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = DEF_WINDOW;
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DATA_W-1:0]  raw_distance = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  filtered_distance;
  int                 fail_count;
  int                 open_count;

  // limits currently programmed, used to aim readings at the edges
  logic [DATA_W-1:0]  cur_low = LOW_LIMIT_RST;
  logic [DATA_W-1:0]  cur_high = HIGH_LIMIT_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  clamped_running_median_filter_core #(.WINDOW(WIN)) dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_distance      (raw_distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .filtered_distance (filtered_distance)
  );

  clamped_running_median_filter_checker #(.WINDOW(WIN)) filter_check (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .raw_distance      (raw_distance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .filtered_distance (filtered_distance),
    .fail_count        (fail_count),
    .open_count        (open_count)
  );

  // mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // readings spread over in-range, out-of-range and boundary values
  function automatic logic [DATA_W-1:0] draw_reading();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return DATA_W'($urandom_range(cur_low, cur_high));
    if (r < 60) return DATA_W'($urandom);
    if (r < 72) return (cur_high == '1) ? cur_high : DATA_W'($urandom_range(cur_high + 1, 65535));
    if (r < 82) return (cur_low == '0) ? cur_low : DATA_W'($urandom_range(0, cur_low - 1));
    case ($urandom_range(0, 5))
      0: return cur_low;
      1: return cur_low - 1'b1;
      2: return cur_high;
      3: return cur_high + 1'b1;
      4: return '0;
      default: return '1;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [DATA_W-1:0] raw, input int unsigned idle);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_distance <= raw;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // drop valid and wait until every median has come out
  task automatic finish_burst();
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOW_LIMIT:  cur_low = val;
      REG_HIGH_LIMIT: cur_high = val;
      default: ;
    endcase
  endtask

  // output stall: random stall bursts, often none at all
  initial begin
    int unsigned free_len;
    int unsigned hold_len;
    forever begin
      free_len = 1 + pick_idle();
      hold_len = pick_idle();
      out_stall <= 1'b0;
      repeat (free_len) @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned random_sent;
    int unsigned burst_len;
    logic [DATA_W-1:0] lo_v;
    logic [DATA_W-1:0] hi_v;
    logic [DATA_W-1:0] fb_v;
    bit busy;

    random_sent = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // reset limits: fallback before any output, low clamp, replace by last median
    send_sample(16'hFFFF, pick_idle());
    send_sample(16'h0000, pick_idle());
    send_sample(16'd19, pick_idle());
    send_sample(16'd20, pick_idle());
    send_sample(16'd1200, pick_idle());
    send_sample(16'd1201, pick_idle());
    send_sample(16'h8000, pick_idle());
    send_sample(16'h0001, pick_idle());
    send_sample(16'h7FFF, pick_idle());
    send_sample(16'd600, pick_idle());
    finish_burst();

    // full range open: zero becomes a genuine median
    apb_write(REG_LOW_LIMIT, 16'h0000);
    apb_write(REG_HIGH_LIMIT, 16'hFFFF);
    apb_write(REG_FALLBACK, 16'h0000);
    send_sample(16'h0000, pick_idle());
    send_sample(16'h0000, pick_idle());
    send_sample(16'h0000, pick_idle());
    send_sample(16'hFFFF, pick_idle());
    finish_burst();

    // zero median then invalid reading: fallback is taken
    apb_write(REG_HIGH_LIMIT, 16'd100);
    apb_write(REG_FALLBACK, 16'd77);
    send_sample(16'd5000, pick_idle());
    send_sample(16'hFFFF, pick_idle());
    finish_burst();

    // low above high: every raised reading is then replaced; unmapped write dropped
    apb_write(REG_LOW_LIMIT, 16'd3000);
    apb_write(REG_HIGH_LIMIT, 16'd1000);
    apb_write(REG_FALLBACK, 16'd555);
    apb_write(REG_UNMAPPED, 16'hFFFF);
    send_sample(16'h0000, pick_idle());
    send_sample(16'd2000, pick_idle());
    send_sample(16'hFFFF, pick_idle());
    send_sample(16'd999, pick_idle());
    finish_burst();

    // all limits at the top
    apb_write(REG_LOW_LIMIT, 16'hFFFF);
    apb_write(REG_HIGH_LIMIT, 16'hFFFF);
    apb_write(REG_FALLBACK, 16'hFFFF);
    send_sample(16'h0000, pick_idle());
    send_sample(16'd12345, pick_idle());
    finish_burst();

    // random bursts, each under a fresh set of limits
    while (random_sent < 1450) begin
      case ($urandom_range(0, 9))
        0: begin
          lo_v = '0;
          hi_v = '1;
        end
        1: begin
          lo_v = DATA_W'($urandom_range(500, 65535));
          hi_v = DATA_W'($urandom_range(0, lo_v));
        end
        2: begin
          lo_v = '1;
          hi_v = DATA_W'($urandom);
        end
        3: begin
          lo_v = '0;
          hi_v = '0;
        end
        default: begin
          lo_v = DATA_W'($urandom_range(0, 400));
          hi_v = lo_v + DATA_W'($urandom_range(0, 4000));
        end
      endcase
      case ($urandom_range(0, 3))
        0: fb_v = '0;
        1: fb_v = DATA_W'($urandom);
        default: fb_v = DATA_W'($urandom_range(0, 2000));
      endcase
      apb_write(REG_LOW_LIMIT, lo_v);
      apb_write(REG_HIGH_LIMIT, hi_v);
      apb_write(REG_FALLBACK, fb_v);
      if ($urandom_range(0, 7) == 0) apb_write(REG_UNMAPPED, DATA_W'($urandom));

      busy = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(20, 120);
      repeat (burst_len) begin
        send_sample(draw_reading(), busy ? 0 : pick_idle());
        random_sent++;
      end
      finish_burst();
    end

    // let any stray word show up
    repeat (4 * (WIN + 3)) @(negedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
